>>> design/assert_macros.svh
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> design/dsa_pkg.sv
`default_nettype none

package dsa_pkg;

  // pool capacities
  localparam int SHADER_SLOTS = 1024;
  localparam int TARGET_SLOTS = 64;
  localparam int DEPTH_SLOTS  = 64;

  // field widths
  localparam int SLOT_W = 10;
  localparam int INC_W  = 11;
  localparam int OFFS_W = 20;
  localparam int MAXS_W = 11;
  localparam int MAXT_W = 7;

  localparam int SHADER_CNT_W = $clog2(SHADER_SLOTS + 1);
  localparam int TARGET_CNT_W = $clog2(TARGET_SLOTS + 1);
  localparam int DEPTH_CNT_W  = $clog2(DEPTH_SLOTS + 1);
  localparam int SMALL_CNT_W  = (TARGET_CNT_W > DEPTH_CNT_W) ? TARGET_CNT_W : DEPTH_CNT_W;
  localparam int CNT_W        = (SHADER_CNT_W > SMALL_CNT_W) ? SHADER_CNT_W : SMALL_CNT_W;

  localparam int SHADER_IDX_W = $clog2(SHADER_SLOTS);
  localparam int TARGET_IDX_W = $clog2(TARGET_SLOTS);
  localparam int DEPTH_IDX_W  = $clog2(DEPTH_SLOTS);

  // all three pools share one stack RAM and one in-use RAM
  localparam int TOTAL_SLOTS = SHADER_SLOTS + TARGET_SLOTS + DEPTH_SLOTS;
  localparam int ADDR_W      = $clog2(TOTAL_SLOTS);
  localparam int TARGET_BASE = SHADER_SLOTS;
  localparam int DEPTH_BASE  = SHADER_SLOTS + TARGET_SLOTS;

  // register port
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam int RST_MAX_SHADER = 1024;
  localparam int RST_MAX_SMALL  = 64;
  localparam int RST_INC        = 32;

  typedef enum logic [0:0] {
    KIND_ALLOC,
    KIND_FREE
  } kind_t;

  typedef enum logic [1:0] {
    POOL_SHADER,
    POOL_TARGET,
    POOL_DEPTH,
    POOL_NONE
  } pool_t;

  typedef enum logic [1:0] {
    ST_OK,
    ST_FULL,
    ST_NEVER,
    ST_DOUBLE
  } status_t;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_MAX_SHADER = 3'd0,
    REG_MAX_TARGET = 3'd1,
    REG_MAX_DEPTH  = 3'd2,
    REG_SHADER_INC = 3'd3,
    REG_TARGET_INC = 3'd4,
    REG_DEPTH_INC  = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [MAXS_W-1:0] max_shader;
    logic [MAXT_W-1:0] max_target;
    logic [MAXT_W-1:0] max_depth;
    logic [INC_W-1:0]  shader_inc;
    logic [INC_W-1:0]  target_inc;
    logic [INC_W-1:0]  depth_inc;
  } cfg_t;

endpackage

`default_nettype wire

>>> design/dsa_ram.sv
`default_nettype none

module dsa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> design/dsa_engine.sv
`default_nettype none

module dsa_engine (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire dsa_pkg::cfg_t               cfg,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        kind,
  input  wire logic [1:0]                  pool,
  input  wire logic [dsa_pkg::SLOT_W-1:0]  slot,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       status,
  output logic [dsa_pkg::SLOT_W-1:0]       granted_slot,
  output logic [dsa_pkg::OFFS_W-1:0]       byte_offset,
  output logic                             reused
);

  localparam int CW = dsa_pkg::CNT_W;
  localparam int AW = dsa_pkg::ADDR_W;
  localparam int SW = dsa_pkg::SLOT_W;
  localparam int PW = dsa_pkg::SLOT_W + dsa_pkg::INC_W;

  typedef enum logic [0:0] {
    S_IDLE,
    S_RESOLVE
  } state_t;

  state_t state;

  // per-pool pointers
  logic [dsa_pkg::SHADER_CNT_W-1:0] shader_count, shader_fresh;
  logic [dsa_pkg::TARGET_CNT_W-1:0] target_count, target_fresh;
  logic [dsa_pkg::DEPTH_CNT_W-1:0]  depth_count,  depth_fresh;

  // request held while the RAMs answer
  dsa_pkg::kind_t req_kind;
  dsa_pkg::pool_t req_pool;
  logic [SW-1:0]  req_slot;

  logic accept, done;

  // lookup side
  logic [AW-1:0] a_base;
  logic [CW-1:0] a_cnt;
  logic [AW-1:0] st_raddr, bm_raddr;

  // resolve side
  logic [AW-1:0]            r_base;
  logic [CW-1:0]            r_cnt, r_fresh, r_limit;
  logic [dsa_pkg::INC_W-1:0] r_inc;
  logic [SW-1:0]            st_rdata;
  logic                     bm_rdata;

  dsa_pkg::status_t res_status;
  logic [SW-1:0]    res_slot;
  logic             res_reused;
  logic             st_we, bm_we, bm_wdata;
  logic [AW-1:0]    st_waddr, bm_waddr;
  logic             cnt_up, cnt_dn, fresh_up;
  logic [PW-1:0]    prod;

  assign in_stall = rst || (state == S_RESOLVE);
  assign accept   = in_valid && !in_stall;
  assign done     = (state == S_RESOLVE) && (!out_valid || !out_stall);

  // read addresses from the incoming word: stack top and the in-use bit of the slot
  always_comb begin
    a_base   = '0;
    a_cnt    = '0;
    bm_raddr = '0;
    unique case (dsa_pkg::pool_t'(pool))
      dsa_pkg::POOL_SHADER: begin
        a_base   = '0;
        a_cnt    = CW'(shader_count);
        bm_raddr = AW'(slot[dsa_pkg::SHADER_IDX_W-1:0]);
      end
      dsa_pkg::POOL_TARGET: begin
        a_base   = AW'(dsa_pkg::TARGET_BASE);
        a_cnt    = CW'(target_count);
        bm_raddr = AW'(dsa_pkg::TARGET_BASE) + AW'(slot[dsa_pkg::TARGET_IDX_W-1:0]);
      end
      dsa_pkg::POOL_DEPTH: begin
        a_base   = AW'(dsa_pkg::DEPTH_BASE);
        a_cnt    = CW'(depth_count);
        bm_raddr = AW'(dsa_pkg::DEPTH_BASE) + AW'(slot[dsa_pkg::DEPTH_IDX_W-1:0]);
      end
      dsa_pkg::POOL_NONE: begin
        a_base   = '0;
        a_cnt    = '0;
        bm_raddr = '0;
      end
    endcase
    st_raddr = a_base + AW'(a_cnt) - AW'(1);
  end

  // pool context for the held request
  always_comb begin
    r_base  = '0;
    r_cnt   = '0;
    r_fresh = '0;
    r_limit = '0;
    r_inc   = '0;
    unique case (req_pool)
      dsa_pkg::POOL_SHADER: begin
        r_cnt   = CW'(shader_count);
        r_fresh = CW'(shader_fresh);
        r_inc   = cfg.shader_inc;
        r_limit = (CW'(cfg.max_shader) < CW'(dsa_pkg::SHADER_SLOTS)) ?
                  CW'(cfg.max_shader) : CW'(dsa_pkg::SHADER_SLOTS);
      end
      dsa_pkg::POOL_TARGET: begin
        r_base  = AW'(dsa_pkg::TARGET_BASE);
        r_cnt   = CW'(target_count);
        r_fresh = CW'(target_fresh);
        r_inc   = cfg.target_inc;
        r_limit = (CW'(cfg.max_target) < CW'(dsa_pkg::TARGET_SLOTS)) ?
                  CW'(cfg.max_target) : CW'(dsa_pkg::TARGET_SLOTS);
      end
      dsa_pkg::POOL_DEPTH: begin
        r_base  = AW'(dsa_pkg::DEPTH_BASE);
        r_cnt   = CW'(depth_count);
        r_fresh = CW'(depth_fresh);
        r_inc   = cfg.depth_inc;
        r_limit = (CW'(cfg.max_depth) < CW'(dsa_pkg::DEPTH_SLOTS)) ?
                  CW'(cfg.max_depth) : CW'(dsa_pkg::DEPTH_SLOTS);
      end
      dsa_pkg::POOL_NONE: begin
        r_base = '0;
      end
    endcase
  end

  // decision and write-back
  always_comb begin
    res_status = dsa_pkg::ST_OK;
    res_slot   = '0;
    res_reused = 1'b0;
    st_we      = 1'b0;
    st_waddr   = r_base + AW'(r_cnt);
    bm_we      = 1'b0;
    bm_waddr   = r_base;
    bm_wdata   = 1'b0;
    cnt_up     = 1'b0;
    cnt_dn     = 1'b0;
    fresh_up   = 1'b0;
    priority if (req_pool == dsa_pkg::POOL_NONE) begin
      res_status = (req_kind == dsa_pkg::KIND_FREE) ? dsa_pkg::ST_NEVER : dsa_pkg::ST_FULL;
    end else if (req_kind == dsa_pkg::KIND_ALLOC) begin
      priority if (r_cnt != '0) begin
        res_slot   = st_rdata;
        res_reused = 1'b1;
        bm_we      = 1'b1;
        bm_waddr   = r_base + AW'(st_rdata);
        bm_wdata   = 1'b1;
        cnt_dn     = 1'b1;
      end else if (r_fresh >= r_limit) begin
        res_status = dsa_pkg::ST_FULL;
      end else begin
        res_slot = SW'(r_fresh);
        bm_we    = 1'b1;
        bm_waddr = r_base + AW'(r_fresh);
        bm_wdata = 1'b1;
        fresh_up = 1'b1;
      end
    end else begin
      // bits above the bump pointer are never used, so no clear is needed
      priority if (CW'(req_slot) >= r_fresh) begin
        res_status = dsa_pkg::ST_NEVER;
      end else if (!bm_rdata) begin
        res_status = dsa_pkg::ST_DOUBLE;
      end else begin
        res_slot = req_slot;
        bm_we    = 1'b1;
        bm_waddr = r_base + AW'(req_slot);
        bm_wdata = 1'b0;
        st_we    = 1'b1;
        cnt_up   = 1'b1;
      end
    end
  end

  assign prod = PW'(res_slot) * PW'(r_inc);

  dsa_ram #(
    .WIDTH (SW),
    .DEPTH (dsa_pkg::TOTAL_SLOTS)
  ) u_stack_ram (
    .clk   (clk),
    .we    (done && st_we),
    .waddr (st_waddr),
    .wdata (req_slot),
    .re    (accept),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  dsa_ram #(
    .WIDTH (1),
    .DEPTH (dsa_pkg::TOTAL_SLOTS)
  ) u_used_ram (
    .clk   (clk),
    .we    (done && bm_we),
    .waddr (bm_waddr),
    .wdata (bm_wdata),
    .re    (accept),
    .raddr (bm_raddr),
    .rdata (bm_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      shader_count <= '0;
      shader_fresh <= '0;
      target_count <= '0;
      target_fresh <= '0;
      depth_count  <= '0;
      depth_fresh  <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state    <= S_RESOLVE;
            req_kind <= dsa_pkg::kind_t'(kind);
            req_pool <= dsa_pkg::pool_t'(pool);
            req_slot <= slot;
          end
        end
        S_RESOLVE: begin
          if (done) begin
            state <= S_IDLE;
            unique case (req_pool)
              dsa_pkg::POOL_SHADER: begin
                if (cnt_dn) begin
                  shader_count <= shader_count - dsa_pkg::SHADER_CNT_W'(1);
                end else if (cnt_up) begin
                  shader_count <= shader_count + dsa_pkg::SHADER_CNT_W'(1);
                end
                if (fresh_up) begin
                  shader_fresh <= shader_fresh + dsa_pkg::SHADER_CNT_W'(1);
                end
              end
              dsa_pkg::POOL_TARGET: begin
                if (cnt_dn) begin
                  target_count <= target_count - dsa_pkg::TARGET_CNT_W'(1);
                end else if (cnt_up) begin
                  target_count <= target_count + dsa_pkg::TARGET_CNT_W'(1);
                end
                if (fresh_up) begin
                  target_fresh <= target_fresh + dsa_pkg::TARGET_CNT_W'(1);
                end
              end
              dsa_pkg::POOL_DEPTH: begin
                if (cnt_dn) begin
                  depth_count <= depth_count - dsa_pkg::DEPTH_CNT_W'(1);
                end else if (cnt_up) begin
                  depth_count <= depth_count + dsa_pkg::DEPTH_CNT_W'(1);
                end
                if (fresh_up) begin
                  depth_fresh <= depth_fresh + dsa_pkg::DEPTH_CNT_W'(1);
                end
              end
              dsa_pkg::POOL_NONE: begin
              end
            endcase
          end
        end
      endcase

      if (done) begin
        out_valid    <= 1'b1;
        status       <= res_status;
        granted_slot <= res_slot;
        byte_offset  <= prod[dsa_pkg::OFFS_W-1:0];
        reused       <= res_reused;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/descriptor_slot_allocator.sv
`default_nettype none

// Slot allocator for three pools: shader-visible (1024 slots), render target
// (64) and depth target (64). Each request word (kind, pool, slot) gives
// exactly one result word (status, granted_slot, byte_offset, reused).
// Allocation pops the pool's free stack first, else issues the bump pointer
// until it meets the smaller of the pool's max register and its capacity.
// A free is refused as never issued when the slot is at or above the bump
// pointer, as a double free when its in-use bit is clear; refused requests
// and pool code 3 leave all state alone and return slot and offset zero.
// Timing: a request word is taken into the request registers while the
// shared stack and in-use RAMs are read, and its result is loaded into the
// output register in the write-back cycle, unless a stalled result still
// occupies it. The next request is taken only after the previous one has
// left the write-back cycle, as each request reads and then writes back the
// RAMs. A new request is taken while the previous result still waits in the
// output register; a stalled output holds the pipeline in the write-back
// cycle. No clearing pass runs after reset: in-use bits at or above a pool's
// bump pointer are never used, so stale RAM contents are harmless. Registers
// sit at byte address 4*i of the APB-style port (max_shader, max_target,
// max_depth, shader_inc, target_inc, depth_inc); write them only while the
// block is idle. pready is tied high.

module descriptor_slot_allocator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  // register port
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [dsa_pkg::PADDR_W-1:0] paddr,
  input  wire logic [dsa_pkg::PDATA_W-1:0] pwdata,
  output logic      [dsa_pkg::PDATA_W-1:0] prdata,
  output logic                             pready,
  // request words
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic                        kind,
  input  wire logic [1:0]                  pool,
  input  wire logic [dsa_pkg::SLOT_W-1:0]  slot,
  // result words
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [1:0]                       status,
  output logic [dsa_pkg::SLOT_W-1:0]       granted_slot,
  output logic [dsa_pkg::OFFS_W-1:0]       byte_offset,
  output logic                             reused
);

  dsa_pkg::cfg_t     cfg;
  dsa_pkg::reg_idx_t reg_idx;
  logic              reg_write;

  assign pready    = 1'b1;
  assign reg_idx   = dsa_pkg::reg_idx_t'(paddr[dsa_pkg::PADDR_W-1:2]);
  assign reg_write = psel && penable && pwrite && pready;

  // configuration registers; writes to unused addresses are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_shader <= dsa_pkg::MAXS_W'(dsa_pkg::RST_MAX_SHADER);
      cfg.max_target <= dsa_pkg::MAXT_W'(dsa_pkg::RST_MAX_SMALL);
      cfg.max_depth  <= dsa_pkg::MAXT_W'(dsa_pkg::RST_MAX_SMALL);
      cfg.shader_inc <= dsa_pkg::INC_W'(dsa_pkg::RST_INC);
      cfg.target_inc <= dsa_pkg::INC_W'(dsa_pkg::RST_INC);
      cfg.depth_inc  <= dsa_pkg::INC_W'(dsa_pkg::RST_INC);
    end else if (reg_write) begin
      unique case (reg_idx)
        dsa_pkg::REG_MAX_SHADER: cfg.max_shader <= pwdata[dsa_pkg::MAXS_W-1:0];
        dsa_pkg::REG_MAX_TARGET: cfg.max_target <= pwdata[dsa_pkg::MAXT_W-1:0];
        dsa_pkg::REG_MAX_DEPTH:  cfg.max_depth  <= pwdata[dsa_pkg::MAXT_W-1:0];
        dsa_pkg::REG_SHADER_INC: cfg.shader_inc <= pwdata[dsa_pkg::INC_W-1:0];
        dsa_pkg::REG_TARGET_INC: cfg.target_inc <= pwdata[dsa_pkg::INC_W-1:0];
        dsa_pkg::REG_DEPTH_INC:  cfg.depth_inc  <= pwdata[dsa_pkg::INC_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // read-back, zero-extended
  always_comb begin
    unique case (reg_idx)
      dsa_pkg::REG_MAX_SHADER: prdata = dsa_pkg::PDATA_W'(cfg.max_shader);
      dsa_pkg::REG_MAX_TARGET: prdata = dsa_pkg::PDATA_W'(cfg.max_target);
      dsa_pkg::REG_MAX_DEPTH:  prdata = dsa_pkg::PDATA_W'(cfg.max_depth);
      dsa_pkg::REG_SHADER_INC: prdata = dsa_pkg::PDATA_W'(cfg.shader_inc);
      dsa_pkg::REG_TARGET_INC: prdata = dsa_pkg::PDATA_W'(cfg.target_inc);
      dsa_pkg::REG_DEPTH_INC:  prdata = dsa_pkg::PDATA_W'(cfg.depth_inc);
      default:                 prdata = '0;
    endcase
  end

  // stack and in-use RAMs, pool pointers and the output register
  dsa_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .pool         (pool),
    .slot         (slot),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .granted_slot (granted_slot),
    .byte_offset  (byte_offset),
    .reused       (reused)
  );

endmodule

`default_nettype wire

>>> design/dsa_checker.sv
`default_nettype none

`include "assert_macros.svh"

module dsa_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_stall,
  input wire logic                        out_valid,
  input wire logic                        out_stall,
  input wire logic [1:0]                  status,
  input wire logic [dsa_pkg::SLOT_W-1:0]  granted_slot,
  input wire logic [dsa_pkg::OFFS_W-1:0]  byte_offset,
  input wire logic                        reused
);

  // stalled result word holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(status) && $stable(granted_slot) && $stable(byte_offset), "stalled result changed")

  // one request at a time through the RAM lookup
  `ASSERT_NEXT(a_busy_after_take, clk, rst, in_valid && !in_stall, in_stall, "request taken while lookup in flight")

  // refused requests carry no slot
  `ASSERT_NOW(a_err_zero, clk, rst, out_valid && (status != dsa_pkg::ST_OK), (granted_slot == '0) && (byte_offset == '0) && !reused, "error result carries a slot")

  `ASSERT_NOW(a_reused_ok, clk, rst, out_valid && reused, status == dsa_pkg::ST_OK, "reused flag on a failed request")

endmodule

bind descriptor_slot_allocator dsa_checker u_dsa_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .status       (status),
  .granted_slot (granted_slot),
  .byte_offset  (byte_offset),
  .reused       (reused)
);

`default_nettype wire
